### src/fbrs_pkg.sv
// shared types, codes and constants for the frame store scanout block
package fbrs_pkg;

  localparam int DEF_MAX_WIDTH  = 320;
  localparam int DEF_MAX_HEIGHT = 240;

  localparam int POS_W    = 10;
  localparam int COLOR_W  = 24;
  localparam int PIX_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int HIDX_W   = 4;
  localparam int PROD_W   = 2 * POS_W + 1;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 9;
  localparam int FW_W     = 9;
  localparam int FH_W     = 8;

  localparam logic [FW_W-1:0] FW_RESET = 9'd320;
  localparam logic [FH_W-1:0] FH_RESET = 8'd240;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  localparam logic [CFG_IW-1:0] CFG_UPSIDE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;

  // window header sequence
  localparam logic [HIDX_W-1:0] HDR_LEN        = 4'd11;
  localparam logic [HIDX_W-1:0] HDR_COL_CMD    = 4'd0;
  localparam logic [HIDX_W-1:0] HDR_COL_END_HI = 4'd3;
  localparam logic [HIDX_W-1:0] HDR_COL_END_LO = 4'd4;
  localparam logic [HIDX_W-1:0] HDR_PAGE_CMD   = 4'd5;
  localparam logic [HIDX_W-1:0] HDR_PG_END_HI  = 4'd8;
  localparam logic [HIDX_W-1:0] HDR_PG_END_LO  = 4'd9;
  localparam logic [HIDX_W-1:0] HDR_MEMWR_CMD  = 4'd10;

  localparam logic [BYTE_W-1:0] OP_COLSET  = 8'h2A;
  localparam logic [BYTE_W-1:0] OP_PAGESET = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_MEMWR   = 8'h2C;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              frame_last;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic tick;
  } scan_req_t;

  function automatic logic [PIX_W-1:0] to_565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:13], c[12:10], c[7:3]};
  endfunction

endpackage

### src/fbrs_ram.sv
// generic single-port ram with registered read
module fbrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/fbrs_wrpath.sv
// pixel write path: range check, mirroring, address and rgb565 packing
module fbrs_wrpath #(
  parameter int DEPTH = fbrs_pkg::DEF_MAX_WIDTH * fbrs_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        upside_down,
  input  logic [fbrs_pkg::POS_W-1:0]  eff_w,
  input  logic [fbrs_pkg::POS_W-1:0]  eff_h,
  input  fbrs_pkg::in_item_t          item,
  output logic                        in_range,
  output logic [AW-1:0]               addr,
  output logic [fbrs_pkg::PIX_W-1:0]  pix
);
  import fbrs_pkg::*;

  logic [POS_W-1:0]  x_m;
  logic [POS_W-1:0]  y_m;
  logic [PROD_W-1:0] lin;

  assign in_range = (item.pos_x < eff_w) && (item.pos_y < eff_h);

  always_comb begin
    if (upside_down) begin
      x_m = eff_w - POS_W'(1) - item.pos_x;
      y_m = eff_h - POS_W'(1) - item.pos_y;
    end else begin
      x_m = item.pos_x;
      y_m = item.pos_y;
    end
    lin = PROD_W'(y_m) * PROD_W'(eff_w) + PROD_W'(x_m);
  end

  assign addr = AW'(lin);
  assign pix  = to_565(item.color);

endmodule

### src/fbrs_scan.sv
// refresh sequencer: window header, column scan and output register
module fbrs_scan #(
  parameter int DEPTH = fbrs_pkg::DEF_MAX_WIDTH * fbrs_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbrs_pkg::scan_req_t        req,
  input  logic [fbrs_pkg::POS_W-1:0] eff_w,
  input  logic [fbrs_pkg::POS_W-1:0] eff_h,
  input  logic [fbrs_pkg::PIX_W-1:0] rd_data,
  output logic                       refresh_busy,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output logic                       out_valid,
  output fbrs_pkg::out_item_t        out_item
);
  import fbrs_pkg::*;

  logic              busy_r, busy_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              lonext_r, lonext_nxt;

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] hbyte_r, hbyte_nxt;
  logic              isdat_r, isdat_nxt;
  logic              last_r, last_nxt;
  logic              pixsel_r, pixsel_nxt;
  logic              losel_r, losel_nxt;
  logic              zero_r, zero_nxt;

  logic              tick_act;
  logic              in_pix;
  logic              row_end;
  logic              col_end;
  logic [POS_W-1:0]  col_w;
  logic [POS_W-1:0]  row_w;
  logic [POS_W-1:0]  hm;
  logic [POS_W-1:0]  wm;
  logic [PROD_W-1:0] lin;
  logic [BYTE_W-1:0] pbyte;

  assign tick_act = req.tick && busy_r;
  assign col_w    = POS_W'(col_r);
  assign row_w    = POS_W'(row_r);
  assign in_pix   = (col_w < eff_w) && (row_w < eff_h);
  assign row_end  = (row_w + POS_W'(1)) >= eff_h;
  assign col_end  = (col_w + POS_W'(1)) >= eff_w;
  assign hm       = eff_h - POS_W'(1);
  assign wm       = eff_w - POS_W'(1);

  // columns run right to left
  assign lin = PROD_W'(row_w) * PROD_W'(eff_w) + PROD_W'(eff_w - POS_W'(1) - col_w);

  always_comb begin
    busy_nxt   = busy_r;
    hidx_nxt   = hidx_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    lonext_nxt = lonext_r;
    vld_nxt    = tick_act;
    hbyte_nxt  = hbyte_r;
    isdat_nxt  = isdat_r;
    last_nxt   = 1'b0;
    pixsel_nxt = pixsel_r;
    losel_nxt  = losel_r;
    zero_nxt   = zero_r;
    rd_en      = 1'b0;
    rd_addr    = in_pix ? AW'(lin) : '0;

    if (req.go && !busy_r) begin
      busy_nxt   = 1'b1;
      hidx_nxt   = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      lonext_nxt = 1'b0;
    end else if (tick_act) begin
      if (hidx_r < HDR_LEN) begin
        pixsel_nxt = 1'b0;
        isdat_nxt  = 1'b1;
        hidx_nxt   = hidx_r + HIDX_W'(1);
        case (hidx_r)
          HDR_COL_CMD: begin
            hbyte_nxt = OP_COLSET;
            isdat_nxt = 1'b0;
          end
          HDR_COL_END_HI: hbyte_nxt = BYTE_W'(hm >> 8);
          HDR_COL_END_LO: hbyte_nxt = hm[7:0];
          HDR_PAGE_CMD: begin
            hbyte_nxt = OP_PAGESET;
            isdat_nxt = 1'b0;
          end
          HDR_PG_END_HI: hbyte_nxt = BYTE_W'(wm >> 8);
          HDR_PG_END_LO: hbyte_nxt = wm[7:0];
          HDR_MEMWR_CMD: begin
            hbyte_nxt = OP_MEMWR;
            isdat_nxt = 1'b0;
          end
          default: hbyte_nxt = '0;
        endcase
      end else begin
        pixsel_nxt = 1'b1;
        isdat_nxt  = 1'b1;
        rd_en      = 1'b1;
        zero_nxt   = !in_pix;
        losel_nxt  = lonext_r;
        lonext_nxt = !lonext_r;
        if (lonext_r) begin
          if (row_end) begin
            row_nxt = '0;
            if (col_end) begin
              last_nxt = 1'b1;
              busy_nxt = 1'b0;
              hidx_nxt = '0;
              col_nxt  = '0;
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      hidx_r   <= '0;
      col_r    <= '0;
      row_r    <= '0;
      lonext_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      hidx_r   <= hidx_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lonext_r <= lonext_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hbyte_r  <= hbyte_nxt;
    isdat_r  <= isdat_nxt;
    last_r   <= last_nxt;
    pixsel_r <= pixsel_nxt;
    losel_r  <= losel_nxt;
    zero_r   <= zero_nxt;
  end

  // pixel bytes come straight off the ram output register
  always_comb begin
    if (zero_r) begin
      pbyte = '0;
    end else if (losel_r) begin
      pbyte = rd_data[7:0];
    end else begin
      pbyte = rd_data[15:8];
    end
  end

  assign refresh_busy        = busy_r;
  assign out_valid           = vld_r;
  assign out_item.out_byte   = pixsel_r ? pbyte : hbyte_r;
  assign out_item.is_data    = isdat_r;
  assign out_item.frame_last = last_r;

endmodule

### src/framebuffer_rotated_spi_scanout_unit.sv
// top level of the frame store with rgb565 panel byte stream
//
//  channel  direction  transfer when          payload
//  in       in         start & !busy          in_data  (cmd, pos_x, pos_y, color)
//  out      out        out_valid, one cycle   out_item (out_byte, is_data, frame_last)
//  cfg      in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// a tick's byte appears on out_* in the next cycle, read through the single ram port.
// clear, and the pass that follows reset, sweep one store entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries (76800 by default) with busy high.
// cfg_ready rises in the cycle after reset is released; writes are taken from then on.
// results cannot be stalled; each is shown for exactly one cycle.
module framebuffer_rotated_spi_scanout_unit #(
  parameter int MAX_WIDTH  = fbrs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fbrs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  fbrs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output fbrs_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fbrs_pkg::CFG_DW-1:0] cfg_data
);
  import fbrs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              rdy_r;
  logic              upside_r;
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;

  logic [POS_W-1:0]  eff_w;
  logic [POS_W-1:0]  eff_h;
  logic              accept;
  logic              refresh_busy;
  scan_req_t         sreq;
  logic              wr_ok;
  logic [AW-1:0]     wr_addr;
  logic [PIX_W-1:0]  wr_pix;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PIX_W-1:0]  ram_wdata;
  logic              clearing;

  // zero or oversize falls back to the full store size
  assign eff_w = (fw_r == '0 || POS_W'(fw_r) > POS_W'(MAX_WIDTH)) ?
                 POS_W'(MAX_WIDTH) : POS_W'(fw_r);
  assign eff_h = (fh_r == '0 || POS_W'(fh_r) > POS_W'(MAX_HEIGHT)) ?
                 POS_W'(MAX_HEIGHT) : POS_W'(fh_r);

  assign clearing  = (state_r == ST_CLEAR);
  assign busy      = clearing;
  assign accept    = start && !busy;
  assign cfg_ready = rdy_r;

  assign sreq.go   = accept && (in_data.cmd == CMD_REFRESH);
  assign sreq.tick = accept && (in_data.cmd == CMD_TICK);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && !refresh_busy && in_data.cmd == CMD_CLEAR) begin
          state_nxt = ST_CLEAR;
          clr_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      rdy_r    <= 1'b0;
      upside_r <= 1'b0;
      fw_r     <= FW_RESET;
      fh_r     <= FH_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rdy_r   <= 1'b1;
      if (cfg_valid && rdy_r) begin
        case (cfg_index)
          CFG_UPSIDE: upside_r <= cfg_data[0];
          CFG_WIDTH:  fw_r     <= cfg_data[FW_W-1:0];
          CFG_HEIGHT: fh_r     <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  fbrs_wrpath #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wrpath (
    .upside_down (upside_r),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .item        (in_data),
    .in_range    (wr_ok),
    .addr        (wr_addr),
    .pix         (wr_pix)
  );

  fbrs_scan #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (sreq),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .rd_data      (rd_data),
    .refresh_busy (refresh_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // clear sweep, pixel write and scan read never share a cycle
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_addr  = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && !refresh_busy && (in_data.cmd == CMD_WRITE) && wr_ok;
      ram_addr  = rd_en ? rd_addr : wr_addr;
      ram_wdata = wr_pix;
    end
  end

  fbrs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (rd_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_data)
  );

endmodule

### src/fbrs_checker.sv
// port-level checks for the scanout unit, bound to the top level
module fbrs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input fbrs_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input fbrs_pkg::out_item_t         out_item,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [fbrs_pkg::CFG_IW-1:0] cfg_index,
  input logic [fbrs_pkg::CFG_DW-1:0] cfg_data
);
  import fbrs_pkg::*;

  // a byte only follows an accepted tick
  a_out_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.cmd == CMD_TICK))
    else $error("result without a preceding tick");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.frame_last) |-> out_item.is_data)
    else $error("frame end flagged on a command byte");

  a_cmd_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.is_data) |->
      (out_item.out_byte == OP_COLSET || out_item.out_byte == OP_PAGESET ||
       out_item.out_byte == OP_MEMWR))
    else $error("unexpected command byte");

  // the store is swept right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("no clearing pass after reset");

endmodule

bind framebuffer_rotated_spi_scanout_unit fbrs_checker u_fbrs_checker (.*);
